// ===== design/upza_pkg.sv =====
package upza_pkg;

    // Zone codes
    localparam logic [1:0] ZONE_CLEAR  = 2'd0;
    localparam logic [1:0] ZONE_GREEN  = 2'd1;
    localparam logic [1:0] ZONE_YELLOW = 2'd2;
    localparam logic [1:0] ZONE_RED    = 2'd3;

    // Previous-zone marker before the first tick
    localparam logic [2:0] ZONE_NONE = 3'd4;

    // Input commands
    localparam logic CMD_ECHO = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_COUNT_SCALE    = 3'd0;
    localparam logic [2:0] REG_FAR_LIMIT      = 3'd1;
    localparam logic [2:0] REG_MID_LIMIT      = 3'd2;
    localparam logic [2:0] REG_NEAR_LIMIT     = 3'd3;
    localparam logic [2:0] REG_TRIGGER_PERIOD = 3'd4;

    // Register reset values
    localparam logic [15:0] COUNT_SCALE_RST    = 16'd5620;
    localparam logic [15:0] FAR_LIMIT_RST      = 16'd2000;
    localparam logic [15:0] MID_LIMIT_RST      = 16'd600;
    localparam logic [15:0] NEAR_LIMIT_RST     = 16'd200;
    localparam logic [7:0]  TRIGGER_PERIOD_RST = 8'd5;

    // Distances in tenths of a cm, saturated
    localparam int          DIST_W   = 13;
    localparam logic [12:0] DIST_MAX = 13'd8191;

    // Beep phase timer in ms
    localparam int PHASE_W = 10;

    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [PHASE_W-1:0] phase_t;

    typedef struct packed {
        logic [15:0] far_lim;
        logic [15:0] mid_lim;
        logic [15:0] near_lim;
    } limits_t;

    typedef struct packed {
        logic [1:0] zone;
        logic [2:0] leds;
        logic       buzz;
        dist_t      dmin;
    } alarm_t;

    // On time of the beep pattern per zone
    function automatic phase_t pattern_on_ms(input logic [1:0] zone);
        phase_t ms;
        case (zone)
            ZONE_GREEN:  ms = 10'd500;
            ZONE_YELLOW: ms = 10'd300;
            ZONE_RED:    ms = 10'd120;
            default:     ms = 10'd0;
        endcase
        return ms;
    endfunction

    // Off time of the beep pattern per zone
    function automatic phase_t pattern_off_ms(input logic [1:0] zone);
        phase_t ms;
        case (zone)
            ZONE_GREEN:  ms = 10'd100;
            ZONE_YELLOW: ms = 10'd90;
            ZONE_RED:    ms = 10'd80;
            default:     ms = 10'd0;
        endcase
        return ms;
    endfunction

endpackage

// ===== design/upza_echo_front.sv =====
module upza_echo_front #(
    parameter int NUM_SENSORS = 3
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      sample_en,
    input  logic                                      tick_en,
    input  logic [NUM_SENSORS-1:0]                    echo_lines,
    input  logic [15:0]                               timer_count,
    input  logic [15:0]                               count_scale,
    output logic [NUM_SENSORS-1:0][upza_pkg::DIST_W-1:0] distances
);

    logic [NUM_SENSORS-1:0]        level_reg;
    logic [NUM_SENSORS-1:0]        ready_reg, ready_next;
    logic [15:0]                   edge_start_reg, edge_start_next;
    logic [NUM_SENSORS-1:0][15:0]  width_reg, width_next;
    logic [NUM_SENSORS-1:0][upza_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [NUM_SENSORS-1:0]        ready_tick;

    // Edge detection; a rise moves the shared start stamp seen by later sensors
    always_comb
    begin
        logic [15:0] start_cur;
        start_cur  = edge_start_reg;
        width_next = width_reg;
        ready_next = ready_reg;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            if (echo_lines[i] && !level_reg[i])
            begin
                start_cur = timer_count;
            end
            else if (!echo_lines[i] && level_reg[i])
            begin
                width_next[i] = timer_count - start_cur;
                ready_next[i] = 1'b1;
            end
        end
        edge_start_next = start_cur;
    end

    // Width to distance, one multiplier per sensor, saturated
    always_comb
    begin
        logic [31:0] prod;
        dist_next  = dist_reg;
        ready_tick = ready_reg;
        prod       = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            prod = {16'd0, width_reg[i]} * {16'd0, count_scale};
            if (ready_reg[i])
            begin
                if (prod[31:16] > {3'd0, upza_pkg::DIST_MAX})
                    dist_next[i] = upza_pkg::DIST_MAX;
                else
                    dist_next[i] = prod[28:16];
                ready_tick[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            ready_reg      <= '0;
            edge_start_reg <= '0;
            width_reg      <= '0;
            dist_reg       <= '0;
        end
        else if (sample_en)
        begin
            level_reg      <= echo_lines;
            ready_reg      <= ready_next;
            edge_start_reg <= edge_start_next;
            width_reg      <= width_next;
        end
        else if (tick_en)
        begin
            ready_reg <= ready_tick;
            dist_reg  <= dist_next;
        end
    end

    assign distances = dist_reg;

endmodule

// ===== design/upza_zone_beep.sv =====
module upza_zone_beep #(
    parameter int NUM_SENSORS = 3,
    parameter int TICK_MS     = 10
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         tick_en,
    input  logic [NUM_SENSORS-1:0][upza_pkg::DIST_W-1:0] distances,
    input  upza_pkg::limits_t                            limits,
    output upza_pkg::alarm_t                             alarm
);

    logic [2:0]       prev_zone_reg, prev_zone_next;
    logic             phase_on_reg, phase_on_next;
    upza_pkg::phase_t elapsed_reg, elapsed_next;
    upza_pkg::dist_t  dmin;
    logic [15:0]      dmin_ext;
    logic [1:0]       zone;
    logic             buzz;

    // Nearest distance
    always_comb
    begin
        dmin = distances[0];
        for (int i = 1; i < NUM_SENSORS; i++)
        begin
            if (distances[i] < dmin)
                dmin = distances[i];
        end
    end

    assign dmin_ext = {3'd0, dmin};

    // Zone classification, tested in priority order
    always_comb
    begin
        if (dmin_ext <= limits.far_lim && dmin_ext >= limits.mid_lim)
            zone = upza_pkg::ZONE_GREEN;
        else if (dmin_ext < limits.mid_lim && dmin_ext >= limits.near_lim)
            zone = upza_pkg::ZONE_YELLOW;
        else if (dmin_ext < limits.near_lim)
            zone = upza_pkg::ZONE_RED;
        else
            zone = upza_pkg::ZONE_CLEAR;
    end

    // Beep pattern; a zone change restarts in the on phase
    always_comb
    begin
        upza_pkg::phase_t on_ms, off_ms, el, el_inc;
        logic             on_cur;
        on_ms  = upza_pkg::pattern_on_ms(zone);
        off_ms = upza_pkg::pattern_off_ms(zone);
        if ({1'b0, zone} != prev_zone_reg)
        begin
            on_cur = (on_ms != '0);
            el     = '0;
        end
        else
        begin
            on_cur = phase_on_reg;
            el     = elapsed_reg;
        end
        el_inc         = el + upza_pkg::PHASE_W'(TICK_MS);
        prev_zone_next = {1'b0, zone};
        phase_on_next  = on_cur;
        elapsed_next   = el;
        buzz           = 1'b0;
        if (zone != upza_pkg::ZONE_CLEAR)
        begin
            buzz         = on_cur;
            elapsed_next = el_inc;
            if (on_cur)
            begin
                if (el_inc >= on_ms)
                begin
                    elapsed_next  = '0;
                    phase_on_next = 1'b0;
                end
            end
            else if (el_inc >= off_ms)
            begin
                elapsed_next  = '0;
                phase_on_next = 1'b1;
            end
        end
    end

    // LEDs, one-hot per zone, all off when clear
    always_comb
    begin
        case (zone)
            upza_pkg::ZONE_GREEN:  alarm.leds = 3'b001;
            upza_pkg::ZONE_YELLOW: alarm.leds = 3'b010;
            upza_pkg::ZONE_RED:    alarm.leds = 3'b100;
            default:               alarm.leds = 3'b000;
        endcase
        alarm.zone = zone;
        alarm.buzz = buzz;
        alarm.dmin = dmin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_zone_reg <= upza_pkg::ZONE_NONE;
            phase_on_reg  <= 1'b0;
            elapsed_reg   <= '0;
        end
        else if (tick_en)
        begin
            prev_zone_reg <= prev_zone_next;
            phase_on_reg  <= phase_on_next;
            elapsed_reg   <= elapsed_next;
        end
    end

endmodule

// ===== design/ultrasonic_parking_zone_alarm_unit.sv =====
// A tick beat's result passes the distance and tick stage registers, then the output register.
// Throughput: one beat per cycle while the output is not stalled; echo samples give no result beat.
// Tick stage: distance multipliers run from the latched widths into the distance
// registers; the alarm stage then forms minimum, zone and beep into the output register.
// Reset (rst_n, async, low): state and configuration registers return to their defaults, no zone yet.
module ultrasonic_parking_zone_alarm_unit #(
    parameter int NUM_SENSORS = 3,
    parameter int TICK_MS     = 10,
    localparam int SENSOR_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic [NUM_SENSORS-1:0] echo_lines,
    input  logic [15:0]            timer_count,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             zone,
    output logic [2:0]             led_lights,
    output logic                   buzzer_drive,
    output logic                   trigger_strobe,
    output logic [SENSOR_W-1:0]    trigger_sensor,
    output logic [12:0]            nearest_distance,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    logic [15:0]          count_scale_reg;
    upza_pkg::limits_t    limits_reg;
    logic [7:0]           period_reg;

    logic                 accept, sample_en, tick_en, advance;
    logic [7:0]           div_reg, div_next, div_inc;
    logic [SENSOR_W-1:0]  next_sensor_reg, next_sensor_next;

    logic                 a_valid_reg;
    logic                 a_strobe_reg;
    logic [SENSOR_W-1:0]  a_sensor_reg;

    logic [NUM_SENSORS-1:0][upza_pkg::DIST_W-1:0] distances;
    upza_pkg::alarm_t     alarm;

    logic                 out_valid_reg;
    upza_pkg::alarm_t     alarm_reg;
    logic                 strobe_reg;
    logic [SENSOR_W-1:0]  sensor_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_scale_reg     <= upza_pkg::COUNT_SCALE_RST;
            limits_reg.far_lim  <= upza_pkg::FAR_LIMIT_RST;
            limits_reg.mid_lim  <= upza_pkg::MID_LIMIT_RST;
            limits_reg.near_lim <= upza_pkg::NEAR_LIMIT_RST;
            period_reg          <= upza_pkg::TRIGGER_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                upza_pkg::REG_COUNT_SCALE:    count_scale_reg     <= cfg_data;
                upza_pkg::REG_FAR_LIMIT:      limits_reg.far_lim  <= cfg_data;
                upza_pkg::REG_MID_LIMIT:      limits_reg.mid_lim  <= cfg_data;
                upza_pkg::REG_NEAR_LIMIT:     limits_reg.near_lim <= cfg_data;
                upza_pkg::REG_TRIGGER_PERIOD: period_reg          <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Handshake: output register drains, tick stage moves on when it can
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = a_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign sample_en = accept && (command == upza_pkg::CMD_ECHO);
    assign tick_en   = accept && (command == upza_pkg::CMD_TICK);

    // Trigger divider and round-robin sensor select
    always_comb
    begin
        div_inc  = div_reg + 8'd1;
        div_next = (div_inc >= period_reg) ? 8'd0 : div_inc;
        if (next_sensor_reg == SENSOR_W'(NUM_SENSORS - 1))
            next_sensor_next = '0;
        else
            next_sensor_next = next_sensor_reg + SENSOR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg         <= '0;
            next_sensor_reg <= '0;
        end
        else if (tick_en)
        begin
            div_reg <= div_next;
            if (div_reg == 8'd0)
                next_sensor_reg <= next_sensor_next;
        end
    end

    // Tick stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (tick_en)
            a_valid_reg <= 1'b1;
        else if (advance)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_en)
        begin
            a_strobe_reg <= (div_reg == 8'd0);
            a_sensor_reg <= (div_reg == 8'd0) ? next_sensor_reg : '0;
        end
    end

    upza_echo_front #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_echo_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_en   (sample_en),
        .tick_en     (tick_en),
        .echo_lines  (echo_lines),
        .timer_count (timer_count),
        .count_scale (count_scale_reg),
        .distances   (distances)
    );

    upza_zone_beep #(
        .NUM_SENSORS (NUM_SENSORS),
        .TICK_MS     (TICK_MS)
    ) u_zone_beep (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (a_valid_reg && advance),
        .distances (distances),
        .limits    (limits_reg),
        .alarm     (alarm)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && a_valid_reg)
        begin
            alarm_reg  <= alarm;
            strobe_reg <= a_strobe_reg;
            sensor_reg <= a_sensor_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign zone             = alarm_reg.zone;
    assign led_lights       = alarm_reg.leds;
    assign buzzer_drive     = alarm_reg.buzz;
    assign trigger_strobe   = strobe_reg;
    assign trigger_sensor   = sensor_reg;
    assign nearest_distance = alarm_reg.dmin;

endmodule

// ===== tb/sv/tb_ultrasonic_parking_zone_alarm_unit.sv =====
`timescale 1ns / 100ps

module tb_ultrasonic_parking_zone_alarm_unit;

    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 4;      // margin after the last expected beat
    localparam int HOLD_CYCLES  = 300;
    localparam int TICK_STEP_MS = 10;
    localparam int MAX_PRINTS   = 40;

    // Indexes past the register map, writes there must change nothing
    localparam logic [2:0] REG_UNUSED_LO = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    // One expected alarm beat
    typedef struct packed {
        logic [1:0]  zone;
        logic [2:0]  leds;
        logic        buzz;
        logic        strobe;
        logic [1:0]  sensor;
        logic [12:0] dmin;
    } alarm_beat_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Block inputs
    logic        in_valid    = 1'b0;
    logic        command     = 1'b0;
    logic [2:0]  echo_lines  = 3'b000;
    logic [15:0] timer_count = 16'h0000;
    logic        out_stall   = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [2:0]  cfg_index   = 3'd0;
    logic [15:0] cfg_data    = 16'h0000;

    // Block outputs
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  zone;
    logic [2:0]  led_lights;
    logic        buzzer_drive;
    logic        trigger_strobe;
    logic [1:0]  trigger_sensor;
    logic [12:0] nearest_distance;
    logic        cfg_ready;

    // Traffic control
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int beats_checked  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    logic [2:0] cur_lines = 3'b000;

    alarm_beat_t alarm_expected[$];

    // Shadow of the configuration registers
    logic [15:0] c_scale  = upza_pkg::COUNT_SCALE_RST;
    logic [15:0] c_far    = upza_pkg::FAR_LIMIT_RST;
    logic [15:0] c_mid    = upza_pkg::MID_LIMIT_RST;
    logic [15:0] c_near   = upza_pkg::NEAR_LIMIT_RST;
    logic [7:0]  c_period = upza_pkg::TRIGGER_PERIOD_RST;

    // Shadow of the block state
    logic [2:0]  p_level     = 3'b000;
    logic [15:0] p_edge      = 16'h0000;
    logic [15:0] p_width [3] = '{default: 16'h0000};
    logic [2:0]  p_ready     = 3'b000;
    logic [12:0] p_dist [3]  = '{default: 13'd0};
    logic [2:0]  p_prev_zone = upza_pkg::ZONE_NONE;
    logic        p_beep_on   = 1'b0;
    logic [9:0]  p_phase     = 10'd0;
    logic [7:0]  p_div       = 8'd0;
    logic [1:0]  p_next      = 2'd0;

    ultrasonic_parking_zone_alarm_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .echo_lines       (echo_lines),
        .timer_count      (timer_count),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .zone             (zone),
        .led_lights       (led_lights),
        .buzzer_drive     (buzzer_drive),
        .trigger_strobe   (trigger_strobe),
        .trigger_sensor   (trigger_sensor),
        .nearest_distance (nearest_distance),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Echo edge tracking, and on a tick the alarm beat it must produce
    task automatic predict_alarm(input logic cmd, input logic [2:0] lines,
                                 input logic [15:0] tc);
        alarm_beat_t b;
        logic [31:0] prod;
        logic [12:0] dmin;
        logic [1:0]  z;
        logic [9:0]  on_ms;
        logic [9:0]  off_ms;
        int i;
        if (cmd == upza_pkg::CMD_ECHO)
        begin
            // sensors in order, a later one sees an edge start just stored
            for (i = 0; i < 3; i++)
            begin
                if (lines[i])
                begin
                    if (!p_level[i])
                    begin
                        p_level[i] = 1'b1;
                        p_edge     = tc;
                    end
                end
                else if (p_level[i])
                begin
                    p_level[i] = 1'b0;
                    p_width[i] = tc - p_edge;
                    p_ready[i] = 1'b1;
                end
            end
            return;
        end
        b = '0;
        // trigger round robin
        if (p_div == 8'd0)
        begin
            b.strobe = 1'b1;
            b.sensor = p_next;
            p_next   = (p_next == 2'd2) ? 2'd0 : p_next + 2'd1;
        end
        p_div = p_div + 8'd1;
        if (p_div >= c_period)
            p_div = 8'd0;
        // fresh widths to distances, saturated
        for (i = 0; i < 3; i++)
        begin
            if (p_ready[i])
            begin
                prod       = 32'(p_width[i]) * 32'(c_scale);
                p_dist[i]  = (prod[31:16] > 16'd8191) ? 13'd8191 : prod[28:16];
                p_ready[i] = 1'b0;
            end
        end
        dmin = p_dist[0];
        for (i = 1; i < 3; i++)
            if (p_dist[i] < dmin)
                dmin = p_dist[i];
        // zone tests in priority order
        if (dmin <= c_far && dmin >= c_mid)
            z = upza_pkg::ZONE_GREEN;
        else if (dmin < c_mid && dmin >= c_near)
            z = upza_pkg::ZONE_YELLOW;
        else if (dmin < c_near)
            z = upza_pkg::ZONE_RED;
        else
            z = upza_pkg::ZONE_CLEAR;
        case (z)
            upza_pkg::ZONE_GREEN:
            begin
                on_ms  = 10'd500;
                off_ms = 10'd100;
            end
            upza_pkg::ZONE_YELLOW:
            begin
                on_ms  = 10'd300;
                off_ms = 10'd90;
            end
            upza_pkg::ZONE_RED:
            begin
                on_ms  = 10'd120;
                off_ms = 10'd80;
            end
            default:
            begin
                on_ms  = 10'd0;
                off_ms = 10'd0;
            end
        endcase
        // a new zone restarts its pattern in the on phase
        if ({1'b0, z} != p_prev_zone)
        begin
            p_beep_on   = (on_ms != 10'd0);
            p_phase     = 10'd0;
            p_prev_zone = {1'b0, z};
        end
        if (on_ms == 10'd0 && off_ms == 10'd0)
            b.buzz = 1'b0;
        else
        begin
            b.buzz  = p_beep_on;
            p_phase = p_phase + 10'(TICK_STEP_MS);
            if (p_beep_on)
            begin
                if (p_phase >= on_ms)
                begin
                    p_phase   = 10'd0;
                    p_beep_on = 1'b0;
                end
            end
            else if (p_phase >= off_ms)
            begin
                p_phase   = 10'd0;
                p_beep_on = 1'b1;
            end
        end
        b.zone = z;
        b.leds = (z == upza_pkg::ZONE_CLEAR) ? 3'b000 : (3'b001 << (z - 2'd1));
        b.dmin = dmin;
        alarm_expected.push_back(b);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t beat %0d: %s got %0d expected %0d",
                     $time, beats_checked, what, got, want);
    endtask

    // Input beat monitor feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            predict_alarm(command, echo_lines, timer_count);
    end

    // Output beat checker
    always @(posedge clk)
    begin : check_beat
        alarm_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (alarm_expected.size() == 0)
                report_mismatch("beat with nothing expected", zone, 0);
            else
            begin
                want = alarm_expected.pop_front();
                if (zone !== want.zone)
                    report_mismatch("zone", zone, want.zone);
                if (led_lights !== want.leds)
                    report_mismatch("led_lights", led_lights, want.leds);
                if (buzzer_drive !== want.buzz)
                    report_mismatch("buzzer_drive", buzzer_drive, want.buzz);
                if (trigger_strobe !== want.strobe)
                    report_mismatch("trigger_strobe", trigger_strobe, want.strobe);
                if (trigger_sensor !== want.sensor)
                    report_mismatch("trigger_sensor", trigger_sensor, want.sensor);
                if (nearest_distance !== want.dmin)
                    report_mismatch("nearest_distance", nearest_distance, want.dmin);
            end
            beats_checked++;
        end
    end

    // Receiver stall, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one input beat and wait until it is taken
    task automatic offer_beat(input logic cmd, input logic [2:0] lines,
                              input logic [15:0] tc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        echo_lines  <= lines;
        timer_count <= tc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (cmd == upza_pkg::CMD_ECHO)
            cur_lines = lines;
    endtask

    task automatic send_echo(input logic [2:0] lines, input logic [15:0] tc);
        offer_beat(upza_pkg::CMD_ECHO, lines, tc);
    endtask

    // Tick beats carry random, unused echo fields
    task automatic send_tick();
        offer_beat(upza_pkg::CMD_TICK, 3'($urandom_range(7)), 16'($urandom_range(65535)));
    endtask

    // Stop sending and wait for every expected beat, then the latency
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (alarm_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register beat; cfg_valid stays up for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            upza_pkg::REG_COUNT_SCALE:    c_scale  = data;
            upza_pkg::REG_FAR_LIMIT:      c_far    = data;
            upza_pkg::REG_MID_LIMIT:      c_mid    = data;
            upza_pkg::REG_NEAR_LIMIT:     c_near   = data;
            upza_pkg::REG_TRIGGER_PERIOD: c_period = data[7:0];
            default:                      ;
        endcase
    endtask

    // Full register setting while idle; upper byte of the period is junk
    task automatic set_config(input logic [15:0] scale, input logic [15:0] far_l,
                              input logic [15:0] mid_l, input logic [15:0] near_l,
                              input logic [7:0] period);
        drain();
        write_reg(upza_pkg::REG_COUNT_SCALE, scale);
        write_reg(upza_pkg::REG_FAR_LIMIT, far_l);
        write_reg(upza_pkg::REG_MID_LIMIT, mid_l);
        write_reg(upza_pkg::REG_NEAR_LIMIT, near_l);
        write_reg(upza_pkg::REG_TRIGGER_PERIOD, {8'($urandom_range(255)), period});
        cfg_valid <= 1'b0;
    endtask

    // Same echo width on all sensors, then a tick to report it
    task automatic measure_all(input logic [15:0] t0, input logic [15:0] w);
        if (cur_lines != 3'b000)
            send_echo(3'b000, t0 - 16'd1);
        send_echo(3'b111, t0);
        send_echo(3'b000, t0 + w);
        send_tick();
    endtask

    // Echo width aimed at a zone limit, or anywhere
    function automatic logic [15:0] pick_width();
        longint target;
        longint w;
        int off;
        case ($urandom_range(5))
            0: w = longint'($urandom_range(65535));
            1: w = longint'($urandom_range(3000));
            2:
            begin
                case ($urandom_range(2))
                    0:       w = 0;
                    1:       w = 1;
                    default: w = 65535;
                endcase
            end
            default:
            begin
                case ($urandom_range(2))
                    0:       target = longint'(c_far);
                    1:       target = longint'(c_mid);
                    default: target = longint'(c_near);
                endcase
                off    = $urandom_range(6);
                target = target + off - 3;
                if (target < 0)
                    target = 0;
                if (target > 8191)
                    target = 8191;
                if (c_scale == 16'd0)
                    w = longint'($urandom_range(65535));
                else
                    w = (target * 65536 + c_scale - 1) / c_scale;
                if (w > 65535)
                    w = 65535;
            end
        endcase
        return w[15:0];
    endfunction

    // Mostly echo pulses and tick bursts, some line noise
    task automatic run_random(input int n);
        int start;
        int k;
        int r;
        logic [2:0]  mask;
        logic [15:0] t0;
        logic [15:0] w;
        start = items_sent;
        while (items_sent - start < n)
        begin
            r = $urandom_range(99);
            if (r < 30)
            begin
                // long bursts let the beep pattern run through its phases
                k = ($urandom_range(5) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 4);
                repeat (k) send_tick();
            end
            else if (r < 88)
            begin
                case ($urandom_range(3))
                    0:       mask = 3'b111;
                    1:       mask = 3'($urandom_range(1, 7));
                    default: mask = 3'b001 << $urandom_range(2);
                endcase
                t0 = 16'($urandom_range(65535));
                w  = pick_width();
                send_echo(cur_lines | mask, t0);
                if ($urandom_range(9) == 0)
                    send_tick();
                send_echo(cur_lines & ~mask, t0 + w);
                if ($urandom_range(1) == 1)
                    send_tick();
            end
            else
                send_echo(3'($urandom_range(7)), 16'($urandom_range(65535)));
        end
    endtask

    // Distances reset to zero: red zone, trigger round robin from sensor 0
    task automatic test_reset_state();
        repeat (3) send_tick();
    endtask

    // Zone limits hit exactly; full scale makes distance = width - 1
    task automatic test_zone_bounds();
        int bounds [5] = '{2001, 2000, 599, 200, 199};
        int i;
        set_config(16'hFFFF, upza_pkg::FAR_LIMIT_RST, upza_pkg::MID_LIMIT_RST,
                   upza_pkg::NEAR_LIMIT_RST, upza_pkg::TRIGGER_PERIOD_RST);
        for (i = 0; i < 5; i++)
        begin
            // first one wraps the timer between rise and fall
            if (i == 0)
                measure_all(16'hFFF0, 16'(bounds[i] + 1));
            else
                measure_all(16'($urandom_range(65535)), 16'(bounds[i] + 1));
        end
    endtask

    // Shared edge start: a fall and a rise in one sample, handled in order
    task automatic test_echo_edge_order();
        send_echo(3'b001, 16'd10);
        send_echo(3'b010, 16'd50);
        send_echo(3'b100, 16'd90);
        send_tick();
        send_echo(3'b011, 16'd130);
        send_echo(3'b000, 16'd200);
        send_tick();
    endtask

    // Distance saturation at full scale, all zero at zero scale
    task automatic test_saturation();
        set_config(16'hFFFF, upza_pkg::FAR_LIMIT_RST, upza_pkg::MID_LIMIT_RST,
                   upza_pkg::NEAR_LIMIT_RST, upza_pkg::TRIGGER_PERIOD_RST);
        measure_all(16'($urandom_range(65535)), 16'hFFFF);
        set_config(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, upza_pkg::TRIGGER_PERIOD_RST);
        measure_all(16'd100, 16'd40000);
    endtask

    // Trigger period: longest, lowered below the divider, zero, one
    task automatic test_trigger_period();
        set_config(upza_pkg::COUNT_SCALE_RST, upza_pkg::FAR_LIMIT_RST,
                   upza_pkg::MID_LIMIT_RST, upza_pkg::NEAR_LIMIT_RST, 8'd255);
        repeat (3) send_tick();
        drain();
        write_reg(upza_pkg::REG_TRIGGER_PERIOD, 16'hA502);
        write_reg(REG_UNUSED_LO, 16'h5A5A);
        write_reg(REG_UNUSED_HI, 16'hFFFF);
        cfg_valid <= 1'b0;
        repeat (2) send_tick();
        drain();
        write_reg(upza_pkg::REG_TRIGGER_PERIOD, 16'hFF00);
        cfg_valid <= 1'b0;
        repeat (3) send_tick();
        drain();
        write_reg(upza_pkg::REG_TRIGGER_PERIOD, 16'h0001);
        cfg_valid <= 1'b0;
        repeat (2) send_tick();
    endtask

    // Random settings under each idling pattern
    task automatic test_random_traffic();
        int send_pcts [4] = '{0, 63, 0, 17};
        int recv_pcts [4] = '{0, 0, 63, 17};
        int ph;
        logic [15:0] near_l;
        logic [15:0] mid_l;
        for (ph = 0; ph < 4; ph++)
        begin
            drain();
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            // ordered limits, typical scale
            near_l = 16'($urandom_range(50, 800));
            mid_l  = near_l + 16'($urandom_range(100, 1500));
            set_config(16'($urandom_range(1500, 16000)),
                       mid_l + 16'($urandom_range(200, 3000)), mid_l, near_l,
                       8'($urandom_range(1, 10)));
            run_random(300);
            // extremes of every register
            set_config(($urandom_range(1) == 1) ? 16'hFFFF : 16'($urandom_range(65535)),
                       ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000,
                       ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000,
                       ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000,
                       ($urandom_range(1) == 1) ? 8'd255 : 8'd1);
            run_random(100);
        end
    endtask

    // Receiver holds off while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(upza_pkg::COUNT_SCALE_RST, upza_pkg::FAR_LIMIT_RST,
                   upza_pkg::MID_LIMIT_RST, upza_pkg::NEAR_LIMIT_RST,
                   upza_pkg::TRIGGER_PERIOD_RST);
        hold_requests++;
        run_random(60);
        drain();
        run_random(20);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_zone_bounds();
        test_echo_edge_order();
        test_saturation();
        test_trigger_period();
        test_random_traffic();
        test_backpressure();
        drain();
        if (alarm_expected.size() != 0)
            report_mismatch("beats never seen", alarm_expected.size(), 0);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
design/upza_pkg.sv
design/upza_echo_front.sv
design/upza_zone_beep.sv
design/ultrasonic_parking_zone_alarm_unit.sv
tb/sv/tb_ultrasonic_parking_zone_alarm_unit.sv
